>>> hdl/apc_pkg.sv
// ============================================================================
// apc_pkg: shared types and constants of the arm preset positioner
// Field widths, register indexes, reset values, preset codes and the
// reciprocal constants used for the divisions by 1000 and by 20000.
// ============================================================================
package apc_pkg;

    // Field and register widths.
    localparam int ANGLE_W       = 12;
    localparam int ERR_W         = 13;
    localparam int DIFF_W        = 14;
    localparam int EMAG_W        = 11;
    localparam int DMAG_W        = 13;
    localparam int GAIN_W        = 16;
    localparam int BAND_W        = 11;
    localparam int SPEED_W       = 10;
    localparam int LEVEL_W       = 11;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;
    localparam int SUM_WIDTH_DEF = 32;

    // Magnitudes entering the divide by 1000 are held to this many bits.
    // Anything larger saturates the drive level in any case.
    localparam int IMAG_W = 28;
    localparam logic [IMAG_W-1:0] IMAG_LIM = '1;

    // Width of the derivative product.
    localparam int PRODD_W = GAIN_W + DMAG_W;

    // Divide by 1000: (x * DIVA_MUL) >> DIVA_SHIFT is exact for x below 2**28.
    localparam int DIVA_MUL_W = 29;
    localparam int DIVA_SHIFT = 38;
    localparam logic [DIVA_MUL_W-1:0] DIVA_MUL = 29'd274877907;

    // Divide by 20000: shift right by DIVB_PRE, then divide by 625 through
    // (x * DIVB_MUL) >> DIVB_SHIFT, exact for x below 2**24.
    localparam int DIVB_PRE   = 5;
    localparam int DIVB_MUL_W = 25;
    localparam int DIVB_SHIFT = 34;
    localparam logic [DIVB_MUL_W-1:0] DIVB_MUL = 25'd27487791;

    // Quotient widths of the three PID terms.
    localparam int QPI_W = 19;
    localparam int QD_W  = 15;

    // Angle wrap bounds and drive limit.
    localparam logic signed [ERR_W-1:0] WRAP_HI   = 13'sd1800;
    localparam logic signed [ERR_W-1:0] WRAP_SPAN = 13'sd3600;
    localparam int LEVEL_MAX = 1000;

    // Preset codes.
    localparam logic [1:0] PRESET_BOTTOM = 2'd1;
    localparam logic [1:0] PRESET_MID    = 2'd2;
    localparam logic [1:0] PRESET_TOP    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MID    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 4'd7;

    // Configuration reset values.
    localparam logic [GAIN_W-1:0]  KP_RST     = 16'd1500;
    localparam logic [GAIN_W-1:0]  KI_RST     = 16'd0;
    localparam logic [GAIN_W-1:0]  KD_RST     = 16'd10;
    localparam logic [ANGLE_W-1:0] BOTTOM_RST = 12'd0;
    localparam logic [ANGLE_W-1:0] MID_RST    = 12'd250;
    localparam logic [ANGLE_W-1:0] TOP_RST    = 12'd1315;
    localparam logic [BAND_W-1:0]  BAND_RST   = 11'd20;
    localparam logic [SPEED_W-1:0] SPEED_RST  = 10'd150;

    // Drive mode of a result.
    typedef enum logic [1:0] {
        MODE_HOLD = 2'd0,
        MODE_PID  = 2'd1,
        MODE_JOG  = 2'd2
    } t_mode;

    // One input request.
    typedef struct packed {
        logic               press_bottom;
        logic               press_mid;
        logic               press_top;
        logic               jog_up;
        logic               jog_down;
        logic [ANGLE_W-1:0] arm_angle;
    } t_item;

    // Error terms after the tracking stage, in sign and magnitude.
    typedef struct packed {
        t_mode             mode;
        logic              jog_neg;
        logic              e_neg;
        logic [EMAG_W-1:0] e_mag;
        logic              i_neg;
        logic [IMAG_W-1:0] i_mag;
        logic              d_neg;
        logic [DMAG_W-1:0] d_mag;
        logic              moving;
        logic [1:0]        preset;
    } t_track;

    // Divided PID terms, in sign and magnitude.
    typedef struct packed {
        t_mode            mode;
        logic             jog_neg;
        logic             p_neg;
        logic [QPI_W-1:0] p_q;
        logic             i_neg;
        logic [QPI_W-1:0] i_q;
        logic             d_neg;
        logic [QD_W-1:0]  d_q;
        logic             moving;
        logic [1:0]       preset;
    } t_terms;

endpackage

>>> hdl/apc_if.sv
// ============================================================================
// apc_if: channel interfaces of the arm preset positioner
// Input request channel, result channel and configuration write channel,
// each with valid, ready and its payload.
// ============================================================================

// Input request channel.
interface apc_in_if import apc_pkg::*;;
    logic               valid;
    logic               ready;
    logic               press_bottom;
    logic               press_mid;
    logic               press_top;
    logic               jog_up;
    logic               jog_down;
    logic [ANGLE_W-1:0] arm_angle;

    modport source (
        output valid, press_bottom, press_mid, press_top, jog_up, jog_down, arm_angle,
        input  ready
    );
    modport sink (
        input  valid, press_bottom, press_mid, press_top, jog_up, jog_down, arm_angle,
        output ready
    );
endinterface

// Result channel.
interface apc_out_if import apc_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] drive_level;
    logic [1:0]                drive_mode;
    logic                      moving;
    logic [1:0]                current_preset;

    modport source (
        output valid, drive_level, drive_mode, moving, current_preset,
        input  ready
    );
    modport sink (
        input  valid, drive_level, drive_mode, moving, current_preset,
        output ready
    );
endinterface

// Configuration write channel.
interface apc_cfg_if import apc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> hdl/apc_track.sv
// ============================================================================
// apc_track: move control and error tracking stage
// Picks a preset, wraps the position error, updates the integral and the
// previous error, ends a move inside the done band and registers the terms.
// ============================================================================
module apc_track import apc_pkg::*; #(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_take,
    input  t_item              i_item,
    input  logic [ANGLE_W-1:0] i_bottom_target,
    input  logic [ANGLE_W-1:0] i_mid_target,
    input  logic [ANGLE_W-1:0] i_top_target,
    input  logic [BAND_W-1:0]  i_done_band,
    output logic               o_valid,
    output t_track             o_track
);

    localparam int EXT_W = SUM_WIDTH + IMAG_W;
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic                        r_run;
    logic [1:0]                  r_preset;
    logic [ANGLE_W-1:0]          r_target;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [ERR_W-1:0]     r_last;
    logic                        r_valid;
    t_track                      r_track;

    logic                        n_run;
    logic [1:0]                  n_preset;
    logic [ANGLE_W-1:0]          n_target;
    t_track                      n_track;

    logic                        start;
    logic                        active;
    logic signed [SUM_WIDTH-1:0] sum_base;
    logic signed [ERR_W-1:0]     last_base;
    logic signed [ERR_W-1:0]     err_raw;
    logic signed [ERR_W-1:0]     err;
    logic [ERR_W-1:0]            err_abs;
    logic signed [DIFF_W-1:0]    diff;
    logic [DIFF_W-1:0]           diff_abs;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_new;
    logic [SUM_WIDTH-1:0]        sum_abs;
    logic [EXT_W-1:0]            sum_ext;
    logic                        done;

    // Preset selection: only while idle, bottom before mid before top,
    // and a button of the current preset is passed over.
    always_comb begin
        start    = 1'b0;
        n_preset = r_preset;
        n_target = r_target;
        if (!r_run) begin
            if (i_item.press_bottom && r_preset != PRESET_BOTTOM) begin
                start    = 1'b1;
                n_preset = PRESET_BOTTOM;
                n_target = i_bottom_target;
            end else if (i_item.press_mid && r_preset != PRESET_MID) begin
                start    = 1'b1;
                n_preset = PRESET_MID;
                n_target = i_mid_target;
            end else if (i_item.press_top && r_preset != PRESET_TOP) begin
                start    = 1'b1;
                n_preset = PRESET_TOP;
                n_target = i_top_target;
            end
        end
    end

    // Error with a single wrap into plus or minus 180 degrees.
    always_comb begin
        active    = r_run | start;
        sum_base  = start ? '0 : r_sum;
        last_base = start ? signed'({1'b0, n_target}) : r_last;
        err_raw   = signed'({1'b0, n_target}) - signed'({1'b0, i_item.arm_angle});
        if (err_raw > WRAP_HI) begin
            err = err_raw - WRAP_SPAN;
        end else if (err_raw < -WRAP_HI) begin
            err = err_raw + WRAP_SPAN;
        end else begin
            err = err_raw;
        end
        err_abs  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        diff     = DIFF_W'(err) - DIFF_W'(last_base);
        diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        done     = err_abs[EMAG_W-1:0] < i_done_band;
        n_run    = active & ~done;
    end

    // Saturating integral and its clamped magnitude.
    always_comb begin
        sum_wide = (SUM_WIDTH+1)'(sum_base) + (SUM_WIDTH+1)'(err);
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            sum_new = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_new = sum_wide[SUM_WIDTH-1:0];
        end
        sum_abs = sum_new[SUM_WIDTH-1] ? (~sum_new + 1'b1) : sum_new;
        sum_ext = EXT_W'(sum_abs);
    end

    // Payload of the next stage.
    always_comb begin
        if (active) begin
            n_track.mode = MODE_PID;
        end else if (i_item.jog_up || i_item.jog_down) begin
            n_track.mode = MODE_JOG;
        end else begin
            n_track.mode = MODE_HOLD;
        end
        n_track.jog_neg = ~i_item.jog_up;
        n_track.e_neg   = err[ERR_W-1];
        n_track.e_mag   = err_abs[EMAG_W-1:0];
        n_track.i_neg   = sum_new[SUM_WIDTH-1];
        n_track.i_mag   = (sum_ext > EXT_W'(IMAG_LIM)) ? IMAG_LIM : sum_ext[IMAG_W-1:0];
        n_track.d_neg   = diff[DIFF_W-1];
        n_track.d_mag   = diff_abs[DMAG_W-1:0];
        n_track.moving  = n_run;
        n_track.preset  = n_preset;
    end

    // Controller state, updated once per accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_preset <= PRESET_BOTTOM;
            r_target <= '0;
            r_sum    <= '0;
            r_last   <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_adv) begin
                r_valid <= i_take;
            end
            if (i_take) begin
                r_run    <= n_run;
                r_preset <= n_preset;
                r_target <= n_target;
                if (active) begin
                    r_sum  <= sum_new;
                    r_last <= err;
                end
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_track <= n_track;
        end
    end

    assign o_valid = r_valid;
    assign o_track = r_track;

endmodule

>>> hdl/apc_terms.sv
// ============================================================================
// apc_terms: PID gain products and constant divisions
// First stage multiplies the error terms by their gains; second stage
// divides them by 1000 and 20000 through reciprocal multiplication.
// ============================================================================
module apc_terms import apc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  t_track            i_track,
    input  logic [GAIN_W-1:0] i_kp,
    input  logic [GAIN_W-1:0] i_ki,
    input  logic [GAIN_W-1:0] i_kd,
    output logic              o_valid,
    output t_terms            o_terms
);

    localparam int PRODP_W = GAIN_W + EMAG_W;
    localparam int PRODI_W = GAIN_W + IMAG_W;
    localparam int QA_W    = IMAG_W + DIVA_MUL_W;
    localparam int DPRE_W  = PRODD_W - DIVB_PRE;
    localparam int QB_W    = DPRE_W + DIVB_MUL_W;

    typedef struct packed {
        t_mode              mode;
        logic               jog_neg;
        logic               p_neg;
        logic [IMAG_W-1:0]  p_prod;
        logic               i_neg;
        logic [IMAG_W-1:0]  i_prod;
        logic               d_neg;
        logic [PRODD_W-1:0] d_prod;
        logic               moving;
        logic [1:0]         preset;
    } t_prod;

    logic               r_valid_b;
    logic               r_valid_c;
    t_prod              r_prod;
    t_terms             r_terms;
    t_prod              n_prod;
    t_terms             n_terms;

    logic [PRODP_W-1:0] p_full;
    logic [PRODI_W-1:0] i_full;
    logic [QA_W-1:0]    p_quot;
    logic [QA_W-1:0]    i_quot;
    logic [QB_W-1:0]    d_quot;

    // Gain products; the integral product is held below 2**28.
    always_comb begin
        p_full          = i_kp * i_track.e_mag;
        i_full          = i_ki * i_track.i_mag;
        n_prod.mode     = i_track.mode;
        n_prod.jog_neg  = i_track.jog_neg;
        n_prod.p_neg    = i_track.e_neg;
        n_prod.p_prod   = IMAG_W'(p_full);
        n_prod.i_neg    = i_track.i_neg;
        n_prod.i_prod   = (i_full > PRODI_W'(IMAG_LIM)) ? IMAG_LIM : i_full[IMAG_W-1:0];
        n_prod.d_neg    = i_track.d_neg;
        n_prod.d_prod   = i_kd * i_track.d_mag;
        n_prod.moving   = i_track.moving;
        n_prod.preset   = i_track.preset;
    end

    // Truncating divisions of the magnitudes by reciprocal multiplication.
    always_comb begin
        p_quot          = r_prod.p_prod * DIVA_MUL;
        i_quot          = r_prod.i_prod * DIVA_MUL;
        d_quot          = r_prod.d_prod[PRODD_W-1:DIVB_PRE] * DIVB_MUL;
        n_terms.mode    = r_prod.mode;
        n_terms.jog_neg = r_prod.jog_neg;
        n_terms.p_neg   = r_prod.p_neg;
        n_terms.p_q     = p_quot[DIVA_SHIFT +: QPI_W];
        n_terms.i_neg   = r_prod.i_neg;
        n_terms.i_q     = i_quot[DIVA_SHIFT +: QPI_W];
        n_terms.d_neg   = r_prod.d_neg;
        n_terms.d_q     = d_quot[DIVB_SHIFT +: QD_W];
        n_terms.moving  = r_prod.moving;
        n_terms.preset  = r_prod.preset;
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b <= 1'b0;
            r_valid_c <= 1'b0;
        end else if (i_adv) begin
            r_valid_b <= i_valid;
            r_valid_c <= r_valid_b;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod  <= n_prod;
            r_terms <= n_terms;
        end
    end

    assign o_valid = r_valid_c;
    assign o_terms = r_terms;

endmodule

>>> hdl/apc_mix.sv
// ============================================================================
// apc_mix: drive level selection and result register
// Sums and saturates the PID terms, or picks the jog or hold level,
// and holds the result until the receiver takes it.
// ============================================================================
module apc_mix import apc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_terms             i_terms,
    input  logic [SPEED_W-1:0] i_manual_speed,
    output logic               o_adv,
    apc_out_if.source          o_out
);

    localparam int TOT_W = QPI_W + 3;
    localparam logic signed [TOT_W-1:0] TOT_MAX = TOT_W'(LEVEL_MAX);
    localparam logic signed [TOT_W-1:0] TOT_MIN = -TOT_W'(LEVEL_MAX);

    logic                      r_valid;
    logic signed [LEVEL_W-1:0] r_level;
    t_mode                     r_mode;
    logic                      r_moving;
    logic [1:0]                r_preset;
    logic signed [LEVEL_W-1:0] n_level;

    logic signed [TOT_W-1:0]   p_s;
    logic signed [TOT_W-1:0]   i_s;
    logic signed [TOT_W-1:0]   d_s;
    logic signed [TOT_W-1:0]   tot;
    logic signed [LEVEL_W-1:0] pid_level;
    logic signed [LEVEL_W-1:0] jog_level;

    // The pipeline moves whenever the result register is free or taken.
    assign o_adv = ~r_valid | o_out.ready;

    // Signed sum of the terms, saturated to the drive range.
    always_comb begin
        p_s = i_terms.p_neg ? -TOT_W'(i_terms.p_q) : TOT_W'(i_terms.p_q);
        i_s = i_terms.i_neg ? -TOT_W'(i_terms.i_q) : TOT_W'(i_terms.i_q);
        d_s = i_terms.d_neg ? -TOT_W'(i_terms.d_q) : TOT_W'(i_terms.d_q);
        tot = p_s + i_s + d_s;
        if (tot > TOT_MAX) begin
            pid_level = LEVEL_W'(TOT_MAX);
        end else if (tot < TOT_MIN) begin
            pid_level = LEVEL_W'(TOT_MIN);
        end else begin
            pid_level = tot[LEVEL_W-1:0];
        end
        jog_level = i_terms.jog_neg ? -LEVEL_W'(i_manual_speed) : LEVEL_W'(i_manual_speed);
    end

    // Level by drive mode; hold and unused codes give zero.
    always_comb begin
        case (i_terms.mode)
            MODE_PID: n_level = pid_level;
            MODE_JOG: n_level = jog_level;
            default:  n_level = '0;
        endcase
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_level  <= n_level;
            r_mode   <= i_terms.mode;
            r_moving <= i_terms.moving;
            r_preset <= i_terms.preset;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.drive_level    = r_level;
    assign o_out.drive_mode     = r_mode;
    assign o_out.moving         = r_moving;
    assign o_out.current_preset = r_preset;

endmodule

>>> hdl/arm_preset_pid_positioner_unit.sv
// ============================================================================
// arm_preset_pid_positioner_unit: PID arm positioner with preset buttons
// Top level: configuration registers and the four-stage pipeline.
// ============================================================================
// Usage:
//   i_in carries one control tick per request: preset and jog buttons and
//   the absolute arm angle. o_out returns exactly one result per request:
//   drive level, drive mode, the moving flag and the current preset.
//   i_cfg writes the gain, target, done band and jog speed registers by
//   index; it is always ready and should be used only while no request is
//   in flight.
//   Pipeline: a request passes the tracking, product, term and result
//   registers in turn. Throughput is one request per cycle unless
//   stalled; the controller state (integral, previous error, move flag and
//   preset) is updated in the accepting cycle, so back-to-back ticks chain
//   correctly, and the gain multiplies and divides follow in later stages.
//   Reset: registers return to their default gains and targets, the block
//   is idle at the bottom preset, and the pipeline is empty.
//   Stall: when a result waits and o_out.ready is low, every stage holds
//   and i_in.ready drops until the result is taken.
// ============================================================================
module arm_preset_pid_positioner_unit import apc_pkg::*; #(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    apc_cfg_if.sink   i_cfg,
    apc_in_if.sink    i_in,
    apc_out_if.source o_out
);

    logic [GAIN_W-1:0]  r_kp;
    logic [GAIN_W-1:0]  r_ki;
    logic [GAIN_W-1:0]  r_kd;
    logic [ANGLE_W-1:0] r_bottom;
    logic [ANGLE_W-1:0] r_mid;
    logic [ANGLE_W-1:0] r_top;
    logic [BAND_W-1:0]  r_band;
    logic [SPEED_W-1:0] r_speed;

    logic   adv;
    logic   take;
    t_item  item;
    logic   track_valid;
    t_track track;
    logic   terms_valid;
    t_terms terms;

    // Configuration register writes.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= KP_RST;
            r_ki     <= KI_RST;
            r_kd     <= KD_RST;
            r_bottom <= BOTTOM_RST;
            r_mid    <= MID_RST;
            r_top    <= TOP_RST;
            r_band   <= BAND_RST;
            r_speed  <= SPEED_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_KP:     r_kp     <= i_cfg.data[GAIN_W-1:0];
                CFG_KI:     r_ki     <= i_cfg.data[GAIN_W-1:0];
                CFG_KD:     r_kd     <= i_cfg.data[GAIN_W-1:0];
                CFG_BOTTOM: r_bottom <= i_cfg.data[ANGLE_W-1:0];
                CFG_MID:    r_mid    <= i_cfg.data[ANGLE_W-1:0];
                CFG_TOP:    r_top    <= i_cfg.data[ANGLE_W-1:0];
                CFG_BAND:   r_band   <= i_cfg.data[BAND_W-1:0];
                CFG_SPEED:  r_speed  <= i_cfg.data[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input request handshake.
    assign i_in.ready = adv;
    assign take       = i_in.valid & adv;

    always_comb begin
        item.press_bottom = i_in.press_bottom;
        item.press_mid    = i_in.press_mid;
        item.press_top    = i_in.press_top;
        item.jog_up       = i_in.jog_up;
        item.jog_down     = i_in.jog_down;
        item.arm_angle    = i_in.arm_angle;
    end

    // Move control and error tracking.
    apc_track #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_take          (take),
        .i_item          (item),
        .i_bottom_target (r_bottom),
        .i_mid_target    (r_mid),
        .i_top_target    (r_top),
        .i_done_band     (r_band),
        .o_valid         (track_valid),
        .o_track         (track)
    );

    // Gain products and divisions.
    apc_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (track_valid),
        .i_track (track),
        .i_kp    (r_kp),
        .i_ki    (r_ki),
        .i_kd    (r_kd),
        .o_valid (terms_valid),
        .o_terms (terms)
    );

    // Level selection and result register.
    apc_mix u_mix (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (terms_valid),
        .i_terms        (terms),
        .i_manual_speed (r_speed),
        .o_adv          (adv),
        .o_out          (o_out)
    );

endmodule
